// ===== src/mrlc_pkg.sv =====
package mrlc_pkg;

    localparam int LineDepth = 128;
    localparam int AddrW     = $clog2(LineDepth);
    localparam int NumPat    = 13;
    localparam int MaxPatLen = 18;
    localparam int PatIdxW   = 4;
    localparam int PatPosW   = 5;

    localparam logic [7:0] ChLf = 8'h0a;
    localparam logic [7:0] ChCr = 8'h0d;

    // pattern indexes
    localparam logic [PatIdxW-1:0] PatUser    = 4'd0;
    localparam logic [PatIdxW-1:0] PatGps     = 4'd1;
    localparam logic [PatIdxW-1:0] PatOk      = 4'd2;
    localparam logic [PatIdxW-1:0] PatSucc    = 4'd3;
    localparam logic [PatIdxW-1:0] PatReg     = 4'd4;
    localparam logic [PatIdxW-1:0] PatMqDis   = 4'd5;
    localparam logic [PatIdxW-1:0] PatNetFail = 4'd6;
    localparam logic [PatIdxW-1:0] PatMqStat  = 4'd7;
    localparam logic [PatIdxW-1:0] PatCsq     = 4'd8;
    localparam logic [PatIdxW-1:0] PatBatOn   = 4'd9;
    localparam logic [PatIdxW-1:0] PatBatOff  = 4'd10;
    localparam logic [PatIdxW-1:0] PatOn      = 4'd11;
    localparam logic [PatIdxW-1:0] PatOff     = 4'd12;

    localparam logic [3:0] ClsNone    = 4'd0;
    localparam logic [3:0] ClsUser    = 4'd1;
    localparam logic [3:0] ClsGps     = 4'd2;
    localparam logic [3:0] ClsOk      = 4'd3;
    localparam logic [3:0] ClsSucc    = 4'd4;
    localparam logic [3:0] ClsReg     = 4'd5;
    localparam logic [3:0] ClsLinkFail = 4'd6;
    localparam logic [3:0] ClsMqDown  = 4'd7;
    localparam logic [3:0] ClsSignal  = 4'd8;

    localparam logic [2:0] KindNone   = 3'd0;
    localparam logic [2:0] KindBatOn  = 3'd1;
    localparam logic [2:0] KindBatOff = 3'd2;
    localparam logic [2:0] KindOn     = 3'd3;
    localparam logic [2:0] KindOff    = 3'd4;

    localparam logic [1:0] GradeNone = 2'd0;
    localparam logic [1:0] GradeLost = 2'd1;
    localparam logic [1:0] GradeBad  = 2'd2;
    localparam logic [1:0] GradeOk   = 2'd3;

    typedef struct packed {
        logic              store;     // write byte at fill index
        logic              clear;     // fill index back to zero
        logic              scan_init; // start scan of a pattern
        logic              scan_step; // compare one stored byte
        logic [PatIdxW-1:0] pat;
        logic              grab_c6;
        logic              grab_c7;
        logic              finish;    // build result from found bits
    } t_cmd;

    typedef struct packed {
        logic [AddrW-1:0] fill;
        logic             scan_done;
        logic             scan_found;
    } t_sts;

    function automatic logic [PatPosW-1:0] pat_len(input logic [PatIdxW-1:0] p);
        unique case (p)
            PatUser:    pat_len = 5'd5;
            PatGps:     pat_len = 5'd6;
            PatOk:      pat_len = 5'd2;
            PatSucc:    pat_len = 5'd7;
            PatReg:     pat_len = 5'd9;
            PatMqDis:   pat_len = 5'd18;
            PatNetFail: pat_len = 5'd13;
            PatMqStat:  pat_len = 5'd13;
            PatCsq:     pat_len = 5'd5;
            PatBatOn:   pat_len = 5'd12;
            PatBatOff:  pat_len = 5'd13;
            PatOn:      pat_len = 5'd4;
            PatOff:     pat_len = 5'd5;
            default:    pat_len = 5'd31;
        endcase
    endfunction

    function automatic logic [8*MaxPatLen-1:0] pat_str(input logic [PatIdxW-1:0] p);
        unique case (p)
            PatUser:    pat_str = 144'("phone");
            PatGps:     pat_str = 144'("$GNRMC");
            PatOk:      pat_str = 144'("OK");
            PatSucc:    pat_str = 144'("SUCCESS");
            PatReg:     pat_str = 144'("+CEREG: 1");
            PatMqDis:   pat_str = 144'("+MQTT:DISCONNECTED");
            PatNetFail: pat_str = 144'("+NETOPEN:FAIL");
            PatMqStat:  pat_str = 144'("+MQTTSTATU: 0");
            PatCsq:     pat_str = 144'("+CSQ:");
            PatBatOn:   pat_str = 144'("\"battery on\"");
            PatBatOff:  pat_str = 144'("\"battery off\"");
            PatOn:      pat_str = 144'("\"on\"");
            PatOff:     pat_str = 144'("\"off\"");
            default:    pat_str = '0;
        endcase
    endfunction

    // character k of pattern p (strings are right aligned)
    function automatic logic [7:0] pat_char(input logic [PatIdxW-1:0] p,
                                            input logic [PatPosW-1:0] k);
        logic [8*MaxPatLen-1:0] s;
        logic [PatPosW-1:0]     l;
        logic [PatPosW-1:0]     sh;
        s  = pat_str(p);
        l  = pat_len(p);
        sh = l - k - 5'd1;
        pat_char = s[8*sh +: 8];
    endfunction

endpackage

// ===== src/mrlc_if.sv =====
interface mrlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrlc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  line_class;
    logic [2:0]  command_kind;
    logic [6:0]  signal_level;
    logic [1:0]  signal_grade;
    logic [15:0] ok_total;
    logic [6:0]  line_length;
    modport source (output valid, output line_class, output command_kind,
                    output signal_level, output signal_grade, output ok_total,
                    output line_length, input ready);
    modport sink (input valid, input line_class, input command_kind,
                  input signal_level, input signal_grade, input ok_total,
                  input line_length, output ready);
endinterface

// ===== src/mrlc_ram.sv =====
module mrlc_ram #(
    parameter int Width = 8,
    parameter int Depth = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/mrlc_datapath.sv =====
module mrlc_datapath
    import mrlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    output t_sts        o_sts,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [3:0]  o_line_class,
    output logic [2:0]  o_command_kind,
    output logic [6:0]  o_signal_level,
    output logic [1:0]  o_signal_grade,
    output logic [15:0] o_ok_total,
    output logic [6:0]  o_line_length
);
    logic [AddrW-1:0]   r_fill, n_fill;
    logic [AddrW-1:0]   r_start;          // match start position
    logic [PatPosW-1:0] r_k;              // offset inside pattern
    logic               r_rd_pend;        // a read is in flight
    logic               r_done, r_found;
    logic [NumPat-1:0]  r_hit;
    logic [7:0]         r_c6, r_c7;
    logic               r_v6, r_v7;
    logic [15:0]        r_okc;
    logic               r_oval;
    logic [AddrW-1:0]   rd_addr;
    logic [7:0]         rd_data;
    logic [AddrW:0]     plen_ext, end_pos;
    logic [7:0]         exp_ch;
    logic               last_k, last_start;

    assign rd_addr = r_start + AddrW'(r_k);

    mrlc_ram #(.Width(8), .Depth(LineDepth)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store),
        .i_waddr(r_fill),
        .i_wdata(i_byte),
        .i_raddr(i_cmd.grab_c6 ? AddrW'(6) : i_cmd.grab_c7 ? AddrW'(7) : rd_addr),
        .o_rdata(rd_data)
    );

    assign plen_ext   = (AddrW+1)'(pat_len(i_cmd.pat));
    assign end_pos    = {1'b0, r_start} + plen_ext;
    assign exp_ch     = pat_char(i_cmd.pat, r_k);
    assign last_k     = (r_k == pat_len(i_cmd.pat) - 5'd1);
    assign last_start = (end_pos >= {1'b0, r_fill});

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.clear) begin
            n_fill = '0;
        end else if (i_cmd.store) begin
            n_fill = r_fill + 1'b1;
        end
    end

    // scan: request read at (start+k), compare next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
            r_rd_pend <= 1'b0;
            r_okc     <= '0;
            r_oval    <= 1'b0;
            r_hit     <= '0;
        end else begin
            r_fill <= n_fill;
            if (o_res_valid && i_res_ready) begin
                r_oval <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_start   <= '0;
                r_k       <= '0;
                r_rd_pend <= 1'b0;
                r_done    <= (plen_ext > {1'b0, r_fill});
                r_found   <= 1'b0;
            end else if (i_cmd.scan_step && !r_done) begin
                if (!r_rd_pend) begin
                    r_rd_pend <= 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                    if (rd_data == exp_ch) begin
                        if (last_k) begin
                            r_done  <= 1'b1;
                            r_found <= 1'b1;
                            r_hit[i_cmd.pat] <= 1'b1;
                        end else begin
                            r_k <= r_k + 5'd1;
                        end
                    end else begin
                        r_k <= '0;
                        if (last_start) begin
                            r_done <= 1'b1;
                        end else begin
                            r_start <= r_start + 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.grab_c6) begin
                r_v6 <= (r_fill > AddrW'(6));
            end
            if (i_cmd.grab_c7) begin
                r_v7 <= (r_fill > AddrW'(7));
                r_c6 <= rd_data;
            end
            if (i_cmd.finish) begin
                r_oval <= 1'b1;
                r_hit  <= '0;
                if (!r_hit[PatUser] && !r_hit[PatGps] && r_hit[PatOk]) begin
                    r_okc <= r_okc + 16'd1;
                end
            end
        end
    end

    logic [3:0] cls;
    logic [2:0] kind;
    logic [6:0] lvl;
    logic [1:0] grd;
    logic       d6, d7;
    logic [7:0] c7;
    logic [6:0] r_lvl_q, r_len_q;
    logic [3:0] r_cls_q;
    logic [2:0] r_kind_q;
    logic [1:0] r_grd_q;

    assign c7 = rd_data;  // char 7 arrives during finish
    assign d6 = r_v6 && r_c6 >= "0" && r_c6 <= "9";
    assign d7 = r_v7 && c7 >= "0" && c7 <= "9";

    always_comb begin
        cls  = ClsNone;
        kind = KindNone;
        lvl  = '0;
        grd  = GradeNone;
        priority if (r_hit[PatUser]) begin
            cls = ClsUser;
            priority if (r_hit[PatBatOn]) kind = KindBatOn;
            else if (r_hit[PatBatOff]) kind = KindBatOff;
            else if (r_hit[PatOn]) kind = KindOn;
            else if (r_hit[PatOff]) kind = KindOff;
            else kind = KindNone;
        end else if (r_hit[PatGps]) begin
            cls = ClsGps;
        end else if (r_hit[PatOk]) begin
            cls = ClsOk;
        end else if (r_hit[PatSucc]) begin
            cls = ClsSucc;
        end else if (r_hit[PatReg]) begin
            cls = ClsReg;
        end else if (r_hit[PatMqDis] || r_hit[PatNetFail]) begin
            cls = ClsLinkFail;
        end else if (r_hit[PatMqStat]) begin
            cls = ClsMqDown;
        end else if (r_hit[PatCsq]) begin
            cls = ClsSignal;
            if (d6) begin
                lvl = 7'(r_c6 - "0");
                if (d7) begin
                    lvl = 7'(lvl * 7'd10) + 7'(c7 - "0");
                end
            end
            if (lvl == 7'd99 || lvl <= 7'd4) grd = GradeLost;
            else if (lvl >= 7'd15) grd = GradeOk;
            else grd = GradeBad;
        end else begin
            cls = ClsNone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_cls_q  <= cls;
            r_kind_q <= kind;
            r_lvl_q  <= lvl;
            r_grd_q  <= grd;
            r_len_q  <= 7'(r_fill);
        end
    end

    assign o_sts.fill       = r_fill;
    assign o_sts.scan_done  = r_done;
    assign o_sts.scan_found = r_found;
    assign o_res_valid    = r_oval;
    assign o_line_class   = r_cls_q;
    assign o_command_kind = r_kind_q;
    assign o_signal_level = r_lvl_q;
    assign o_signal_grade = r_grd_q;
    assign o_ok_total     = r_okc;
    assign o_line_length  = r_len_q;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_oval)
        else $error("result not raised after finish");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> !i_cmd.clear && !i_cmd.scan_step)
        else $error("store overlaps other work");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_done)
        else $error("found without done");
endmodule

// ===== src/mrlc_ctrl.sv =====
module mrlc_ctrl
    import mrlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte,
    input  logic       i_res_busy,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_NEXT = 7'b0001000,
        S_C6   = 7'b0010000,
        S_C7   = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [PatIdxW-1:0] r_pat, n_pat;
    logic               acc, term;

    // data bytes are taken even while a result waits on the output
    assign o_in_ready = (r_state == S_IDLE);
    assign acc  = i_in_valid && o_in_ready;
    assign term = (i_byte == ChLf) || (i_byte == ChCr);

    // pattern order: phone first, then the command kinds only when phone matched, else the other classes
    always_comb begin
        n_state = r_state;
        n_pat   = r_pat;
        o_cmd   = '0;
        o_cmd.pat = r_pat;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (!term) begin
                        if (i_sts.fill == AddrW'(LineDepth-1)) o_cmd.clear = 1'b1;
                        else o_cmd.store = 1'b1;
                    end else if (i_sts.fill != '0) begin
                        n_pat   = PatUser;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_NEXT;
            end
            S_NEXT: begin
                n_state = S_INIT;
                priority if (r_pat == PatUser && i_sts.scan_found) begin
                    n_pat = PatBatOn;
                end else if (r_pat >= PatBatOn) begin
                    if (i_sts.scan_found || r_pat == PatOff) n_state = S_C6;
                    else n_pat = r_pat + 4'd1;
                end else if (i_sts.scan_found || r_pat == PatCsq) begin
                    n_state = S_C6;
                end else begin
                    n_pat = r_pat + 4'd1;
                end
            end
            S_C6: begin
                // hold here until the previous result has left
                o_cmd.grab_c6 = 1'b1;
                if (!i_res_busy) n_state = S_C7;
            end
            S_C7: begin
                o_cmd.grab_c7 = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                o_cmd.clear  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pat   <= PatUser;
        end else begin
            r_state <= n_state;
            r_pat   <= n_pat;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("finish not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_C6 && !i_res_busy |=> r_state == S_C7)
        else $error("char grab out of order");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_cmd.scan_step)
        else $error("ready during scan");
endmodule

// ===== src/modem_response_line_classifier.sv =====
// channel   dir  handshake        payload
// s_in      in   valid/ready      rx_byte
// m_out     out  valid/ready      class, kind, level, grade, ok total, length
//
// a data byte is stored while the block is idle; a terminator walks the line once per
// pattern, reading and comparing one stored byte at a time, for at most nine patterns;
// no bytes are taken until the line has been classified
// synchronous active-low reset; no clearing pass, the store needs none
// data bytes flow while a result waits; a terminator holds in its first character-grab
// state until the output register is free

module modem_response_line_classifier
    import mrlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mrlc_in_if.sink    s_in,
    mrlc_out_if.source m_out
);
    t_cmd cmd;
    t_sts sts;

    mrlc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_in.valid),
        .o_in_ready(s_in.ready),
        .i_byte    (s_in.rx_byte),
        .i_res_busy(m_out.valid),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    mrlc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_byte        (s_in.rx_byte),
        .o_sts         (sts),
        .o_res_valid   (m_out.valid),
        .i_res_ready   (m_out.ready),
        .o_line_class  (m_out.line_class),
        .o_command_kind(m_out.command_kind),
        .o_signal_level(m_out.signal_level),
        .o_signal_grade(m_out.signal_grade),
        .o_ok_total    (m_out.ok_total),
        .o_line_length (m_out.line_length)
    );
endmodule

// ===== tb/testbench.sv =====
module testbench;
    import mrlc_pkg::*;

    typedef struct {
        logic [3:0]  cls;
        logic [2:0]  kind;
        logic [6:0]  level;
        logic [1:0]  grade;
        logic [15:0] oks;
        logic [6:0]  len;
    } t_line_res;

    typedef struct {
        string      text;
        logic [7:0] term;
        bit         typed;
        logic [3:0] cls;
        logic [2:0] kind;
        logic [6:0] level;
        logic [1:0] grade;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    mrlc_in_if  in_if ();
    mrlc_out_if out_if ();

    modem_response_line_classifier DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .m_out   (out_if)
    );

    // model of the line store
    logic [7:0]  line_buf [LineDepth];
    int          line_fill;
    logic [15:0] ok_seen;

    t_line_res   pending_lines [$];
    t_line_res   typed_res;
    bit          typed_armed;
    int          errors;
    int          bytes_sent;
    int          lines_checked;
    int          class_hits [9];
    bit          quiet;
    bit          drained;
    int          holdoff_req;
    int          holdoff_seen;
    int          holdoff_cnt;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit line_holds(input string p);
        int  n;
        bit  hit;
        n = p.len();
        if (n > line_fill) return 1'b0;
        for (int s = 0; s + n <= line_fill; s++) begin
            hit = 1'b1;
            for (int k = 0; k < n; k++) begin
                if (line_buf[s + k] != p[k]) begin
                    hit = 1'b0;
                    break;
                end
            end
            if (hit) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int char_at(input int pos);
        if (pos >= line_fill) return -1;
        return line_buf[pos];
    endfunction

    function automatic bit is_num(input int c);
        return c >= "0" && c <= "9";
    endfunction

    // returns 1 when the byte closes a non-empty line
    function automatic bit classify_byte(input logic [7:0] b, output t_line_res r);
        int c6;
        int c7;
        int lvl;
        r = '{ClsNone, KindNone, 7'd0, GradeNone, 16'd0, 7'd0};
        if (b != ChLf && b != ChCr) begin
            if (line_fill < LineDepth - 1) begin
                line_buf[line_fill] = b;
                line_fill++;
            end else begin
                line_fill = 0;
            end
            return 1'b0;
        end
        if (line_fill == 0) return 1'b0;
        r.len = line_fill[6:0];
        if (line_holds("phone")) begin
            r.cls = ClsUser;
            if (line_holds("\"battery on\""))       r.kind = KindBatOn;
            else if (line_holds("\"battery off\"")) r.kind = KindBatOff;
            else if (line_holds("\"on\""))          r.kind = KindOn;
            else if (line_holds("\"off\""))         r.kind = KindOff;
        end else if (line_holds("$GNRMC")) begin
            r.cls = ClsGps;
        end else if (line_holds("OK")) begin
            r.cls = ClsOk;
            ok_seen = ok_seen + 16'd1;
        end else if (line_holds("SUCCESS")) begin
            r.cls = ClsSucc;
        end else if (line_holds("+CEREG: 1")) begin
            r.cls = ClsReg;
        end else if (line_holds("+MQTT:DISCONNECTED") || line_holds("+NETOPEN:FAIL")) begin
            r.cls = ClsLinkFail;
        end else if (line_holds("+MQTTSTATU: 0")) begin
            r.cls = ClsMqDown;
        end else if (line_holds("+CSQ:")) begin
            r.cls = ClsSignal;
            c6 = char_at(6);
            c7 = char_at(7);
            lvl = 0;
            if (is_num(c6)) begin
                lvl = c6 - "0";
                if (is_num(c7)) lvl = lvl * 10 + (c7 - "0");
            end
            r.level = lvl[6:0];
            if (lvl == 99 || lvl <= 4) r.grade = GradeLost;
            else if (lvl >= 15)        r.grade = GradeOk;
            else                       r.grade = GradeBad;
        end
        r.oks = ok_seen;
        line_fill = 0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_line_res r;
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
        if (classify_byte(b, r)) begin
            if (typed_armed) begin
                r.cls   = typed_res.cls;
                r.kind  = typed_res.kind;
                r.level = typed_res.level;
                r.grade = typed_res.grade;
                typed_armed = 1'b0;
            end
            pending_lines.push_back(r);
        end
        if (!quiet && $urandom_range(0, 99) < 23) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // receiver: random stalls, quiet window, and long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            holdoff_cnt  <= 0;
            holdoff_seen <= 0;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen <= holdoff_req;
            holdoff_cnt  <= 600;
            out_if.ready <= 1'b0;
        end else if (holdoff_cnt > 0) begin
            holdoff_cnt  <= holdoff_cnt - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= quiet || ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        t_line_res e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_lines.size() == 0) begin
                $display("%0t: unexpected line beat class=%0d len=%0d", $time,
                         out_if.line_class, out_if.line_length);
                errors++;
            end else begin
                e = pending_lines.pop_front();
                lines_checked++;
                if (e.cls <= ClsSignal) class_hits[e.cls]++;
                if (out_if.line_class !== e.cls || out_if.command_kind !== e.kind ||
                    out_if.signal_level !== e.level || out_if.signal_grade !== e.grade ||
                    out_if.ok_total !== e.oks || out_if.line_length !== e.len) begin
                    $display("%0t: mismatch exp cls=%0d kind=%0d lvl=%0d grd=%0d ok=%0d len=%0d",
                             $time, e.cls, e.kind, e.level, e.grade, e.oks, e.len);
                    $display("%0t:          got cls=%0d kind=%0d lvl=%0d grd=%0d ok=%0d len=%0d",
                             $time, out_if.line_class, out_if.command_kind,
                             out_if.signal_level, out_if.signal_grade,
                             out_if.ok_total, out_if.line_length);
                    errors++;
                end
            end
        end
    end

    t_dir_row dir_rows [] = '{
        '{"OK",                     ChCr, 1, ClsOk,       KindNone,   7'd0,  GradeNone},
        '{"phone \"battery on\"",   ChLf, 1, ClsUser,     KindBatOn,  7'd0,  GradeNone},
        '{"phone \"battery off\"",  ChLf, 1, ClsUser,     KindBatOff, 7'd0,  GradeNone},
        '{"phone:\"on\"",           ChLf, 1, ClsUser,     KindOn,     7'd0,  GradeNone},
        '{"phone:\"off\"",          ChCr, 1, ClsUser,     KindOff,    7'd0,  GradeNone},
        '{"OK phone",               ChLf, 1, ClsUser,     KindNone,   7'd0,  GradeNone},
        '{"$GNRMC,1,A",             ChLf, 1, ClsGps,      KindNone,   7'd0,  GradeNone},
        '{"SUCCESS",                ChLf, 1, ClsSucc,     KindNone,   7'd0,  GradeNone},
        '{"+CEREG: 1",              ChLf, 1, ClsReg,      KindNone,   7'd0,  GradeNone},
        '{"+MQTT:DISCONNECTED",     ChLf, 1, ClsLinkFail, KindNone,   7'd0,  GradeNone},
        '{"+NETOPEN:FAIL",          ChCr, 1, ClsLinkFail, KindNone,   7'd0,  GradeNone},
        '{"+MQTTSTATU: 0",          ChLf, 1, ClsMqDown,   KindNone,   7'd0,  GradeNone},
        '{"+CSQ: 99,99",            ChLf, 1, ClsSignal,   KindNone,   7'd99, GradeLost},
        '{"+CSQ: 4,0",              ChLf, 1, ClsSignal,   KindNone,   7'd4,  GradeLost},
        '{"+CSQ: 5,0",              ChLf, 1, ClsSignal,   KindNone,   7'd5,  GradeBad},
        '{"+CSQ: 14",               ChLf, 1, ClsSignal,   KindNone,   7'd14, GradeBad},
        '{"+CSQ: 15x",              ChLf, 1, ClsSignal,   KindNone,   7'd15, GradeOk},
        '{"+CSQ: 98",               ChCr, 1, ClsSignal,   KindNone,   7'd98, GradeOk},
        '{"+CSQ: 7",                ChLf, 1, ClsSignal,   KindNone,   7'd7,  GradeBad},
        '{"+CSQ: x9",               ChLf, 1, ClsSignal,   KindNone,   7'd0,  GradeLost},
        '{"+CSQ:",                  ChLf, 1, ClsSignal,   KindNone,   7'd0,  GradeLost},
        '{"hello",                  ChLf, 1, ClsNone,     KindNone,   7'd0,  GradeNone},
        '{"",                       ChLf, 0, ClsNone,     KindNone,   7'd0,  GradeNone},
        '{"O",                      ChCr, 0, ClsNone,     KindNone,   7'd0,  GradeNone}
    };

    string templates [] = '{
        "phone", "phone \"battery on\"", "phone \"battery off\"", "phone \"on\"",
        "phone \"off\"", "$GNRMC,", "OK", "SUCCESS", "+CEREG: 1", "+CEREG: 0",
        "+MQTT:DISCONNECTED", "+NETOPEN:FAIL", "+MQTTSTATU: 0", "+MQTTSTATU: 1",
        "+CSQ: ", "+CSQ:", "OK\"on\"", "\"off\""
    };

    task automatic random_line();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // raw noise, terminators included
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 12) begin
            // long line, around the overflow point
            n = $urandom_range(110, 135);
            repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7e)));
            send_byte($urandom_range(0, 1) ? ChLf : ChCr);
            return;
        end
        if (pick < 40) begin
            // signal report with one or two characters, mostly digits, at times a comma
            if ($urandom_range(0, 4) == 0) send_byte("x");
            send_text("+CSQ: ");
            if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(8'h20, 8'h7e)));
            else send_byte(8'($urandom_range("0", "9")));
            case ($urandom_range(0, 3))
                0: send_byte(",");
                1: ;
                default: send_byte(8'($urandom_range("0", "9")));
            endcase
            if ($urandom_range(0, 1)) send_text(",99");
        end else begin
            n = $urandom_range(0, 2);
            repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7e)));
            send_text(templates[$urandom_range(0, templates.size() - 1)]);
            n = $urandom_range(0, 4);
            repeat (n) send_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                               : $urandom_range(8'h20, 8'h7e)));
        end
        send_byte($urandom_range(0, 1) ? ChLf : ChCr);
        if ($urandom_range(0, 9) == 0) send_byte(ChLf);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = 8'h00;
        line_fill     = 0;
        ok_seen       = 16'd0;
        typed_armed   = 1'b0;
        errors        = 0;
        bytes_sent    = 0;
        lines_checked = 0;
        quiet         = 1'b0;
        drained       = 1'b0;
        holdoff_req   = 0;
        foreach (class_hits[i]) class_hits[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_text(dir_rows[i].text);
            typed_res   = '{dir_rows[i].cls, dir_rows[i].kind, dir_rows[i].level,
                            dir_rows[i].grade, 16'd0, 7'd0};
            typed_armed = dir_rows[i].typed;
            send_byte(dir_rows[i].term);
            typed_armed = 1'b0;
        end
        // zero bytes are ordinary characters
        send_byte("O");
        send_byte(8'h00);
        send_byte("K");
        send_byte(ChLf);
        // overflow: the 128th character restarts the line and is lost
        repeat (130) send_byte("A");
        send_byte(ChLf);

        // long receiver hold-off while bytes keep coming
        holdoff_req++;
        repeat (6) random_line();

        while (bytes_sent < 1800) begin
            quiet = (bytes_sent > 700 && bytes_sent < 1000);
            random_line();
            if (!drained && bytes_sent > 1200) begin
                // sender pause until the block has drained
                drained = 1'b1;
                in_if.valid <= 1'b0;
                while (pending_lines.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end
        quiet = 1'b0;
        in_if.valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);

        $display("sent %0d bytes, checked %0d lines, ok lines %0d, signal reports %0d",
                 bytes_sent, lines_checked, class_hits[ClsOk], class_hits[ClsSignal]);
        $display("user commands %0d, unclassified %0d, mismatches %0d",
                 class_hits[ClsUser], class_hits[ClsNone], errors);
        if (errors == 0 && pending_lines.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("timeout with %0d lines outstanding", pending_lines.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
